// File: rtl/newline_line_framer_defines.svh
// Assertion macros for the newline line framer checker.
// No dependencies; included by files that carry assertions.
`ifndef NEWLINE_LINE_FRAMER_DEFINES_SVH
`define NEWLINE_LINE_FRAMER_DEFINES_SVH

// Checked only while out of reset.
`define NLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define NLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/nlf_pkg.sv
// Shared types and constants of the newline line framer.
// No dependencies.
package nlf_pkg;

  localparam int LINE_BYTES = 64;
  localparam int POS_W      = $clog2(LINE_BYTES);
  localparam int LEN_W      = 6;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_RESYNC = 1'b1;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_EMIT  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } lfr_in_t;

  typedef struct packed {
    logic [7:0]       line_byte;
    logic [LEN_W-1:0] line_length;
    logic             last;
  } lfr_out_t;

  // pos holds the store address for a store, the line length for an emit
  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } nlf_cmd_t;

  typedef struct packed {
    logic     push;
    nlf_cmd_t cmd;
  } nlf_push_t;

  typedef struct packed {
    logic     empty;
    logic     full;
    nlf_cmd_t head;
  } nlf_qstat_t;

endpackage

// File: rtl/nlf_front.sv
// Front end: accepts input words, tracks line position and drain flag,
// and issues store/emit commands. Depends on nlf_pkg.
module nlf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nlf_pkg::lfr_in_t   in_data,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  input  logic               q_full,
  output nlf_pkg::nlf_push_t q_push
);
  import nlf_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             drain_r, drain_nxt;
  logic             sink_r;
  logic             acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    pos_nxt        = pos_r;
    drain_nxt      = drain_r;
    q_push.push    = 1'b0;
    q_push.cmd     = '0;
    q_push.cmd.data = in_data.data_byte;
    if (acc) begin
      if (in_data.operation == OP_RESYNC) begin
        pos_nxt   = '0;
        drain_nxt = 1'b0;
      end else if (in_data.data_byte == CHAR_CR) begin
        pos_nxt = pos_r;
      end else if (in_data.data_byte == CHAR_LF) begin
        if (!drain_r && sink_r && pos_r != '0) begin
          q_push.push     = 1'b1;
          q_push.cmd.kind = CMD_EMIT;
          q_push.cmd.pos  = pos_r;
        end
        pos_nxt   = '0;
        drain_nxt = 1'b0;
      end else if (!drain_r) begin
        if (pos_r == POS_W'(LINE_BYTES - 1)) begin
          pos_nxt   = '0;
          drain_nxt = 1'b1;
        end else begin
          q_push.push     = 1'b1;
          q_push.cmd.kind = CMD_STORE;
          q_push.cmd.pos  = pos_r;
          pos_nxt         = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      drain_r <= 1'b0;
      sink_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      drain_r <= drain_nxt;
      if (cfg_valid) sink_r <= cfg_data;
    end
  end

endmodule

// File: rtl/nlf_queue.sv
// Small command queue between front and back ends.
// Depends on nlf_pkg.
module nlf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  nlf_pkg::nlf_push_t  q_push,
  input  logic                q_pop,
  output nlf_pkg::nlf_qstat_t q_stat
);
  import nlf_pkg::*;

  nlf_cmd_t          ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.head  = ent_r[rd_r];
  assign do_pop       = q_pop && !q_stat.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push.push && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!q_push.push && do_pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (q_push.push) ent_r[wr_r] <= q_push.cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push.push) wr_r <= wr_r + QPTR_W'(1);
      if (do_pop) rd_r <= rd_r + QPTR_W'(1);
    end
  end

endmodule

// File: rtl/nlf_back.sv
// Back end: owns the line store, executes store commands and streams
// completed lines out. Depends on nlf_pkg.
module nlf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  nlf_pkg::nlf_qstat_t q_stat,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output nlf_pkg::lfr_out_t   out_data
);
  import nlf_pkg::*;

  logic [7:0]       mem [LINE_BYTES];
  logic [7:0]       rd_q;
  logic             emit_r, emit_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic             is_last;
  logic             take;

  assign q_pop   = !emit_r && !q_stat.empty;
  assign is_last = (idx_r == len_r - POS_W'(1));
  assign take    = emit_r && out_ready;

  always_comb begin
    emit_nxt = emit_r;
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    if (take) begin
      if (is_last) emit_nxt = 1'b0;
      else idx_nxt = idx_r + POS_W'(1);
    end else if (q_pop && q_stat.head.kind == CMD_EMIT) begin
      emit_nxt = 1'b1;
      idx_nxt  = '0;
      len_nxt  = q_stat.head.pos;
    end
  end

  // rd_q tracks the entry at idx_r while a line is streamed out
  always_ff @(posedge clk) begin
    if (q_pop && q_stat.head.kind == CMD_STORE) mem[q_stat.head.pos] <= q_stat.head.data;
    rd_q <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
    end else begin
      emit_r <= emit_nxt;
    end
    idx_r <= idx_nxt;
    len_r <= len_nxt;
  end

  assign out_valid            = emit_r;
  assign out_data.line_byte   = rd_q;
  assign out_data.line_length = LEN_W'(len_r);
  assign out_data.last        = is_last;

endmodule

// File: rtl/newline_line_framer.sv
// Top level of the newline line framer: front end, command queue, back end.
// Depends on nlf_pkg, nlf_front, nlf_queue, nlf_back.
//
//   channel | dir | handshake          | word
//   in_     | in  | in_valid/in_ready   | lfr_in_t  {operation, data_byte}
//   out_    | out | out_valid/out_ready | lfr_out_t {line_byte, line_length, last}
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_data = sink_enable
//
// Input: one word per cycle while the 4-entry command queue has room.
// Output: one line byte per cycle while out_ready is high, from the store's registered read port.
//   Between lines the queue drains one command per cycle; the output stays idle
//   while the emit pop and any store commands queued ahead of it are taken.
// A line being streamed out holds the queue, and in_ready drops once it fills.
// Synchronous active-low reset; no clearing pass, cfg_ready always high.
module newline_line_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nlf_pkg::lfr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output nlf_pkg::lfr_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import nlf_pkg::*;

  nlf_push_t  q_push;
  nlf_qstat_t q_stat;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  nlf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_stat.full),
    .q_push    (q_push)
  );

  nlf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_stat (q_stat)
  );

  nlf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/nlf_checker.sv
// Port-level checks for the newline line framer, bound to the top level.
// Depends on nlf_pkg and newline_line_framer_defines.svh.
`include "newline_line_framer_defines.svh"

module nlf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input nlf_pkg::lfr_out_t out_data
);
  import nlf_pkg::*;

  `NLF_ASSERT_ALWAYS(a_idle_after_rst, !rst_n |=> !out_valid, "output valid right after reset")
  `NLF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")
  `NLF_ASSERT(a_len_nonzero, out_valid |-> out_data.line_length != '0, "zero line length")
  `NLF_ASSERT(a_line_cont, out_valid && out_ready && !out_data.last |=> out_valid && out_data.line_length == $past(out_data.line_length), "line broken before last")

endmodule

bind newline_line_framer nlf_checker u_nlf_checker (.*);
